// ----- hdl/sact_pkg.sv -----
// Shared types, constants and the CRC-8 step for the command transport.
// Used by the front, engine and top modules; depends on nothing.
`default_nettype none
package sact_pkg;

  localparam int MAX_WRITE = 512;
  localparam int PAY_AW = (MAX_WRITE > 1) ? $clog2(MAX_WRITE) : 1;
  localparam int CDB_LEN = 12;
  localparam int HDR_CRC_POS = 18;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_RX    = 3'd2;
  localparam logic [2:0] CMD_SLOT  = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_DATA_TIMEOUT = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NO_ACK  = 2'd2;

  localparam logic [7:0] BYTE_ACK       = 8'h06;
  localparam logic [7:0] BYTE_NAK       = 8'h15;
  localparam logic [7:0] BYTE_CONTINUED = 8'h02;
  localparam logic [7:0] BYTE_GOOD      = 8'h50;

  localparam logic [7:0] PREAMBLE [4] = '{8'h40, 8'h55, 8'h78, 8'h40};
  localparam logic [7:0] CRC_BITS [8] =
    '{8'h5E, 8'hBC, 8'h61, 8'hC2, 8'h9D, 8'h23, 8'h46, 8'h8C};

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  load_index;
    logic [7:0]  data_byte;
    logic [7:0]  direction;
    logic [15:0] read_length;
    logic [9:0]  write_length;
    logic        continued;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        rd_last;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  error_status;
    logic [7:0]  sense_code;
  } out_item_t;

  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] x);
    logic [7:0] b;
    logic [7:0] r;
    b = acc ^ x;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ CRC_BITS[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sact_ram.sv -----
// Generic single-port-write, registered-read RAM.
// Self-contained; used for the write payload store.
`default_nettype none
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/sact_front.sv -----
// Front end: accepts input transfers, drops unknown commands and queues
// the rest in a two-entry queue. Depends on sact_pkg.
`default_nettype none
module sact_front import sact_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          q_valid,
  output in_item_t      q_data,
  input  wire logic     q_pop
);
  in_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       known;

  assign known    = (in_data.command <= CMD_TICK);
  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sact_engine.sv -----
// Back end: runs the exchange sequencer on queued items, one per cycle unless the
// result register it holds is stalled. Depends on sact_pkg and sact_ram.
`default_nettype none
module sact_engine import sact_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  input  wire in_item_t q_data,
  output logic          q_pop,
  input  wire logic     cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_TX_PRE, PH_ACK1, PH_TX_HDR, PH_ACK2, PH_TX_PAY,
    PH_ACK3, PH_STAT, PH_TX_RESP, PH_DATA, PH_CHK, PH_TX_FIN
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] counter, counter_next;
  logic [7:0]  crc, crc_next;
  logic [15:0] timer, timer_next;
  logic [7:0]  sv_dir, sv_dir_next;
  logic [15:0] sv_rlen, sv_rlen_next;
  logic [9:0]  sv_wlen, sv_wlen_next;
  logic        sv_cont, sv_cont_next;
  logic [7:0]  sv_err, sv_err_next;
  logic [7:0]  sv_sense, sv_sense_next;
  logic [15:0] ack_to, data_to;
  logic [7:0]  cdb [CDB_LEN];
  logic        emit;
  out_item_t   res;
  logic [10:0] pay_off;
  logic        ram_we;
  logic [7:0]  pay_byte;
  logic [7:0]  hdr_byte;
  logic [7:0]  b;
  logic [15:0] lim;

  assign q_pop   = q_valid && (!out_valid || out_ready);
  assign pay_off = {1'b0, q_data.load_index} - 11'd12;
  assign ram_we  = q_pop && (q_data.command == CMD_LOAD) && (phase == PH_IDLE) &&
                   (q_data.load_index >= 10'd12) && (32'(pay_off) < MAX_WRITE);

  sact_ram #(.WIDTH(8), .DEPTH(MAX_WRITE)) u_payload (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pay_off[PAY_AW-1:0]),
    .wdata (q_data.data_byte),
    .raddr (counter_next[PAY_AW-1:0]),
    .rdata (pay_byte)
  );

  always_comb begin
    case (counter[4:0])
      5'd12:   hdr_byte = sv_dir;
      5'd14:   hdr_byte = sv_wlen[7:0];
      5'd15:   hdr_byte = {6'd0, sv_wlen[9:8]};
      5'd16:   hdr_byte = sv_rlen[7:0];
      5'd17:   hdr_byte = sv_rlen[15:8];
      default: hdr_byte = (counter < 16'(CDB_LEN)) ? cdb[counter[3:0]] : 8'd0;
    endcase
  end

  always_comb begin
    phase_next    = phase;
    counter_next  = counter;
    crc_next      = crc;
    timer_next    = timer;
    sv_dir_next   = sv_dir;
    sv_rlen_next  = sv_rlen;
    sv_wlen_next  = sv_wlen;
    sv_cont_next  = sv_cont;
    sv_err_next   = sv_err;
    sv_sense_next = sv_sense;
    emit          = 1'b0;
    res           = '0;
    b             = 8'd0;
    lim           = ack_to;
    if (q_pop) begin
      case (q_data.command)
        CMD_START: begin
          if (phase == PH_IDLE) begin
            sv_dir_next   = q_data.direction;
            sv_rlen_next  = q_data.read_length;
            sv_wlen_next  = (32'(q_data.write_length) > MAX_WRITE) ?
                            10'(MAX_WRITE) : q_data.write_length;
            sv_cont_next  = q_data.continued;
            sv_err_next   = 8'd0;
            sv_sense_next = 8'd0;
            counter_next  = '0;
            crc_next      = '0;
            timer_next    = '0;
            phase_next    = PH_TX_PRE;
          end
        end
        CMD_RX: begin
          case (phase)
            PH_ACK1, PH_ACK2, PH_ACK3: begin
              if (q_data.data_byte != BYTE_ACK) begin
                phase_next   = PH_IDLE;
                emit         = 1'b1;
                res.done_res = 1'b1;
                res.status   = ST_NO_ACK;
              end else begin
                counter_next = '0;
                crc_next     = '0;
                if (phase == PH_ACK1) phase_next = PH_TX_HDR;
                else if (phase == PH_ACK2 && sv_wlen != 10'd0) phase_next = PH_TX_PAY;
                else begin
                  phase_next = PH_STAT;
                  timer_next = '0;
                end
              end
            end
            PH_STAT: begin
              if (counter == 16'd0) begin
                sv_err_next  = q_data.data_byte;
                counter_next = 16'd1;
              end else begin
                sv_sense_next = q_data.data_byte;
                phase_next    = PH_TX_RESP;
              end
            end
            PH_DATA: begin
              emit        = 1'b1;
              res.rd_valid = 1'b1;
              res.rd_byte  = q_data.data_byte;
              res.rd_last  = ({1'b0, counter} + 17'd1 >= {1'b0, sv_rlen});
              if (res.rd_last) begin
                phase_next   = PH_CHK;
                timer_next   = '0;
                counter_next = '0;
                crc_next     = '0;
              end else begin
                counter_next = counter + 16'd1;
              end
            end
            PH_CHK:  phase_next = PH_TX_FIN;
            default: ;
          endcase
        end
        CMD_SLOT: begin
          case (phase)
            PH_TX_PRE: begin
              b = sv_cont ? BYTE_CONTINUED : PREAMBLE[counter[1:0]];
              if (sv_cont || counter >= 16'd3) begin
                phase_next   = PH_ACK1;
                timer_next   = '0;
                counter_next = '0;
                crc_next     = '0;
              end else begin
                counter_next = counter + 16'd1;
              end
              emit = 1'b1;
            end
            PH_TX_HDR: begin
              if (counter < 16'(HDR_CRC_POS)) begin
                b            = hdr_byte;
                crc_next     = crc_step(crc, hdr_byte);
                counter_next = counter + 16'd1;
              end else begin
                b            = crc;
                phase_next   = PH_ACK2;
                timer_next   = '0;
                counter_next = '0;
                crc_next     = '0;
              end
              emit = 1'b1;
            end
            PH_TX_PAY: begin
              if (counter < {6'd0, sv_wlen}) begin
                b            = pay_byte;
                crc_next     = crc_step(crc, pay_byte);
                counter_next = counter + 16'd1;
              end else begin
                b            = crc;
                phase_next   = PH_ACK3;
                timer_next   = '0;
                counter_next = '0;
                crc_next     = '0;
              end
              emit = 1'b1;
            end
            PH_TX_RESP: begin
              emit = 1'b1;
              if (sv_err != BYTE_GOOD) begin
                b            = BYTE_NAK;
                phase_next   = PH_IDLE;
                res.done_res = 1'b1;
              end else if (sv_rlen == 16'd0) begin
                b            = BYTE_ACK;
                phase_next   = PH_IDLE;
                res.done_res = 1'b1;
              end else begin
                b            = BYTE_ACK;
                phase_next   = PH_DATA;
                timer_next   = '0;
                counter_next = '0;
                crc_next     = '0;
              end
            end
            PH_TX_FIN: begin
              b            = BYTE_ACK;
              phase_next   = PH_IDLE;
              emit         = 1'b1;
              res.done_res = 1'b1;
            end
            default: ;
          endcase
          res.tx_valid = emit;
          res.tx_byte  = b;
        end
        CMD_TICK: begin
          lim = (phase == PH_DATA) ? data_to : ack_to;
          if (phase == PH_DATA || phase == PH_ACK1 || phase == PH_ACK2 ||
              phase == PH_ACK3 || phase == PH_STAT || phase == PH_CHK) begin
            if (timer >= lim) begin
              phase_next   = PH_IDLE;
              emit         = 1'b1;
              res.done_res = 1'b1;
              res.status   = ST_TIMEOUT;
            end else begin
              timer_next = timer + 16'd1;
            end
          end
        end
        default: ;
      endcase
      if (res.done_res) begin
        res.error_status = sv_err;
        res.sense_code   = sv_sense;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.command == CMD_LOAD && phase == PH_IDLE &&
        q_data.load_index < 10'(CDB_LEN)) begin
      cdb[q_data.load_index[3:0]] <= q_data.data_byte;
    end
    if (emit) out_data <= res;
    if (rst) begin
      phase     <= PH_IDLE;
      counter   <= '0;
      crc       <= '0;
      timer     <= '0;
      sv_dir    <= '0;
      sv_rlen   <= '0;
      sv_wlen   <= '0;
      sv_cont   <= 1'b0;
      sv_err    <= '0;
      sv_sense  <= '0;
      ack_to    <= 16'd2000;
      data_to   <= 16'd3000;
      out_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      counter  <= counter_next;
      crc      <= crc_next;
      timer    <= timer_next;
      sv_dir   <= sv_dir_next;
      sv_rlen  <= sv_rlen_next;
      sv_wlen  <= sv_wlen_next;
      sv_cont  <= sv_cont_next;
      sv_err   <= sv_err_next;
      sv_sense <= sv_sense_next;
      if (cfg_valid && cfg_index == REG_ACK_TIMEOUT) ack_to <= cfg_data;
      if (cfg_valid && cfg_index == REG_DATA_TIMEOUT) data_to <= cfg_data;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    emit && res.done_res |=> phase == PH_IDLE)
    else $error("finished exchange did not return to idle");
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.tx_valid && out_data.rd_valid))
    else $error("result carries both a link byte and a read byte");
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.done_res)
    else $error("error status without completion");
  a_no_pop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !q_pop)
    else $error("item consumed while result register is blocked");
endmodule
`default_nettype wire

// ----- hdl/serial_atapi_command_transport.sv -----
// Command transport top level: front queue plus exchange engine.
// An accepted item waits in the front queue; its result is registered when it is popped.
// Throughput: one item per cycle while the result register is not stalled, set by the
// engine step and the payload RAM's prefetched registered read.
// Reset: synchronous rst clears queue, phase, counters and the result valid flag;
// timeouts return to 2000 and 3000 ms. Depends on sact_pkg, sact_front, sact_engine.
`default_nettype none
module serial_atapi_command_transport import sact_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic     q_valid;
  logic     q_pop;
  in_item_t q_data;

  assign cfg_ready = 1'b1;

  sact_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  sact_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

// ----- bench/tb_serial_atapi_command_transport.sv -----
// Self-checking bench for the serial command transport: drives load, start,
// link byte, slot and tick commands and compares every result with a predictor.
// Depends on sact_pkg and serial_atapi_command_transport.
`default_nettype none
module tb_serial_atapi_command_transport import sact_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    XP_IDLE, XP_TX_PRE, XP_ACK1, XP_TX_HDR, XP_ACK2, XP_TX_PAY, XP_ACK3,
    XP_STAT, XP_TX_RESP, XP_DATA, XP_CHK, XP_TX_FIN
  } xchg_phase_e;

  class exchange_scoreboard;
    logic [15:0] ack_lim, data_lim;
    xchg_phase_e ph;
    logic [7:0] cdb [CDB_LEN];
    logic [7:0] pay [MAX_WRITE];
    int cnt;
    logic [7:0] crc;
    int timer;
    logic [7:0] dir;
    logic [15:0] rlen;
    int wlen;
    logic cont;
    logic [7:0] err_b, sense_b;
    out_item_t pending [$];
    int errors;

    function new();
      ack_lim = 16'd2000;
      data_lim = 16'd3000;
      ph = XP_IDLE;
      cnt = 0; crc = 0; timer = 0; dir = 0; rlen = 0; wlen = 0; cont = 0;
      err_b = 0; sense_b = 0; errors = 0;
      foreach (cdb[i]) cdb[i] = 0;
      foreach (pay[i]) pay[i] = 0;
    endfunction

    function logic [7:0] crc_next(logic [7:0] acc, logic [7:0] x);
      logic [7:0] v;
      logic [7:0] r;
      v = acc ^ x;
      r = 0;
      for (int i = 0; i < 8; i++) if (v[i]) r ^= CRC_BITS[i];
      return r;
    endfunction

    function void push(logic txv, logic [7:0] txb, logic rv, logic [7:0] rb,
                       logic rl, logic dn, logic [1:0] st);
      out_item_t o;
      o.tx_valid = txv; o.tx_byte = txb; o.rd_valid = rv; o.rd_byte = rb;
      o.rd_last = rl; o.done_res = dn; o.status = dn ? st : ST_OK;
      o.error_status = dn ? err_b : 8'h00;
      o.sense_code = dn ? sense_b : 8'h00;
      pending.push_back(o);
    endfunction

    function void open_wait(xchg_phase_e p);
      ph = p; timer = 0; cnt = 0; crc = 0;
    endfunction

    function logic [7:0] hdr_byte(int i);
      if (i < CDB_LEN) return cdb[i];
      case (i)
        12: return dir;
        14: return wlen[7:0];
        15: return wlen[15:8];
        16: return rlen[7:0];
        17: return rlen[15:8];
        default: return 8'h00;
      endcase
    endfunction

    function void note_input(in_item_t it);
      logic [7:0] b;
      int lim;
      case (it.command)
        CMD_LOAD: if (ph == XP_IDLE) begin
          if (it.load_index < CDB_LEN) cdb[it.load_index] = it.data_byte;
          else if (it.load_index - CDB_LEN < MAX_WRITE)
            pay[it.load_index - CDB_LEN] = it.data_byte;
        end
        CMD_START: if (ph == XP_IDLE) begin
          wlen = (it.write_length > MAX_WRITE) ? MAX_WRITE : it.write_length;
          dir = it.direction; rlen = it.read_length; cont = it.continued;
          err_b = 0; sense_b = 0; cnt = 0; crc = 0; timer = 0;
          ph = XP_TX_PRE;
        end
        CMD_RX: case (ph)
          XP_ACK1, XP_ACK2, XP_ACK3: begin
            if (it.data_byte != BYTE_ACK) begin
              ph = XP_IDLE;
              push(0, 0, 0, 0, 0, 1, ST_NO_ACK);
            end else if (ph == XP_ACK1) begin
              ph = XP_TX_HDR; cnt = 0; crc = 0;
            end else if (ph == XP_ACK2 && wlen > 0) begin
              ph = XP_TX_PAY; cnt = 0; crc = 0;
            end else open_wait(XP_STAT);
          end
          XP_STAT: if (cnt == 0) begin
            err_b = it.data_byte; cnt = 1;
          end else begin
            sense_b = it.data_byte; ph = XP_TX_RESP;
          end
          XP_DATA: begin
            logic last;
            last = (cnt + 1 >= rlen);
            push(0, 0, 1, it.data_byte, last, 0, ST_OK);
            if (last) open_wait(XP_CHK);
            else cnt++;
          end
          XP_CHK: ph = XP_TX_FIN;
          default: ;
        endcase
        CMD_SLOT: case (ph)
          XP_TX_PRE: begin
            b = cont ? BYTE_CONTINUED : PREAMBLE[cnt & 3];
            if (cont || cnt >= 3) open_wait(XP_ACK1);
            else cnt++;
            push(1, b, 0, 0, 0, 0, ST_OK);
          end
          XP_TX_HDR: begin
            if (cnt < HDR_CRC_POS) begin
              b = hdr_byte(cnt); crc = crc_next(crc, b); cnt++;
            end else begin
              b = crc; open_wait(XP_ACK2);
            end
            push(1, b, 0, 0, 0, 0, ST_OK);
          end
          XP_TX_PAY: begin
            if (cnt < wlen) begin
              b = pay[cnt]; crc = crc_next(crc, b); cnt++;
            end else begin
              b = crc; open_wait(XP_ACK3);
            end
            push(1, b, 0, 0, 0, 0, ST_OK);
          end
          XP_TX_RESP: begin
            if (err_b != BYTE_GOOD) begin
              ph = XP_IDLE; push(1, BYTE_NAK, 0, 0, 0, 1, ST_OK);
            end else if (rlen == 0) begin
              ph = XP_IDLE; push(1, BYTE_ACK, 0, 0, 0, 1, ST_OK);
            end else begin
              open_wait(XP_DATA); push(1, BYTE_ACK, 0, 0, 0, 0, ST_OK);
            end
          end
          XP_TX_FIN: begin
            ph = XP_IDLE; push(1, BYTE_ACK, 0, 0, 0, 1, ST_OK);
          end
          default: ;
        endcase
        CMD_TICK: begin
          lim = -1;
          if (ph == XP_DATA) lim = data_lim;
          else if (ph inside {XP_ACK1, XP_ACK2, XP_ACK3, XP_STAT, XP_CHK}) lim = ack_lim;
          if (lim >= 0) begin
            if (timer >= lim) begin
              ph = XP_IDLE; push(0, 0, 0, 0, 0, 1, ST_TIMEOUT);
            end else timer++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  exchange_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  localparam int WATCHDOG_LIMIT = 20000;

  always #6 clk = ~clk;

  serial_atapi_command_transport dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic send_cmd(logic [2:0] c, logic [9:0] idx, logic [7:0] db);
    in_item_t it;
    it = '0;
    it.command = c; it.load_index = idx; it.data_byte = db;
    it.direction = 8'($urandom); it.read_length = 16'($urandom);
    it.write_length = 10'($urandom); it.continued = 1'($urandom);
    send_item(it);
  endtask

  task automatic start_xchg(logic [7:0] d, logic [15:0] rl, logic [9:0] wl, logic c);
    in_item_t it;
    it = '0;
    it.command = CMD_START; it.load_index = 10'($urandom); it.data_byte = 8'($urandom);
    it.direction = d; it.read_length = rl; it.write_length = wl; it.continued = c;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == REG_ACK_TIMEOUT) sb.ack_lim = val;
    else sb.data_lim = val;
    @(posedge clk);
  endtask

  task automatic load_all(int wl);
    for (int i = 0; i < CDB_LEN; i++) send_cmd(CMD_LOAD, i, $urandom);
    for (int i = 0; i < wl && i < MAX_WRITE; i++) send_cmd(CMD_LOAD, CDB_LEN + i, $urandom);
  endtask

  // One exchange following the protocol; fault selects a broken variant.
  task automatic exchange(int wl, int rl, int fault);
    int slots;
    load_all(wl);
    start_xchg($urandom, rl, wl, $urandom_range(1));
    for (int s = 0; s < 4; s++) send_cmd(CMD_SLOT, $urandom, $urandom);
    if (fault == 1) begin
      send_cmd(CMD_RX, $urandom, 8'h07);
      return;
    end
    send_cmd(CMD_RX, $urandom, BYTE_ACK);
    for (int s = 0; s < 19; s++) send_cmd(CMD_SLOT, $urandom, $urandom);
    send_cmd(CMD_RX, $urandom, BYTE_ACK);
    slots = (wl > MAX_WRITE ? MAX_WRITE : wl);
    if (slots > 0) begin
      for (int s = 0; s <= slots; s++) send_cmd(CMD_SLOT, $urandom, $urandom);
      send_cmd(CMD_RX, $urandom, (fault == 2) ? 8'h15 : BYTE_ACK);
      if (fault == 2) return;
    end
    if ($urandom_range(3) == 0) send_cmd(CMD_TICK, $urandom, $urandom);
    send_cmd(CMD_RX, $urandom, (fault == 3) ? $urandom : BYTE_GOOD);
    send_cmd(CMD_RX, $urandom, $urandom);
    send_cmd(CMD_SLOT, $urandom, $urandom);
    for (int s = 0; s < rl; s++) send_cmd(CMD_RX, $urandom, $urandom);
    send_cmd(CMD_RX, $urandom, $urandom);
    send_cmd(CMD_SLOT, $urandom, $urandom);
    send_cmd(CMD_SLOT, $urandom, $urandom);
  endtask

  task automatic timeout_run(int ticks);
    start_xchg($urandom, 0, 0, 1);
    send_cmd(CMD_SLOT, 0, 0);
    for (int t = 0; t < ticks; t++) send_cmd(CMD_TICK, $urandom, $urandom);
    send_cmd(CMD_RX, 0, BYTE_ACK);
    for (int s = 0; s < 20; s++) send_cmd(CMD_SLOT, 0, 0);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70) exchange($urandom_range(4) == 0 ? $urandom_range(6) : 0,
                           $urandom_range(5), $urandom_range(9) < 7 ? 0 : $urandom_range(1, 3));
      else if (r < 80) exchange($urandom_range(3), $urandom_range(3), 0);
      else begin
        in_item_t it;
        it = $bits(in_item_t)'({$urandom, $urandom});
        it.command = 3'($urandom_range(7));
        if (it.command == CMD_LOAD)
          it.load_index = 10'($urandom_range(CDB_LEN + MAX_WRITE - 1));
        if (it.command == CMD_START) begin
          it.write_length = 0;
          load_all(0);
        end
        send_item(it);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    exchange(0, 0, 0);
    exchange(3, 2, 0);
    exchange(0, 1, 3);
    exchange(0, 0, 1);
    exchange(2, 0, 2);
    send_cmd(CMD_LOAD, 10'h3FF, 8'hFF);
    send_cmd(3'd7, 10'h3FF, 8'hFF);
    send_cmd(CMD_TICK, 0, 0);
    send_cmd(CMD_RX, 0, 8'hFF);
    load_all(0);
    start_xchg(8'hFF, 16'd0, 10'h3FF, 0);
    for (int s = 0; s < 4; s++) send_cmd(CMD_SLOT, 0, 0);
    send_cmd(CMD_LOAD, 0, 8'h11);
    start_xchg(8'h00, 16'hFFFF, 0, 0);
    send_cmd(CMD_RX, 0, BYTE_ACK);
    for (int s = 0; s < 19; s++) send_cmd(CMD_SLOT, 0, 0);
    send_cmd(CMD_RX, 0, BYTE_NAK);
    drain();

    write_reg(REG_ACK_TIMEOUT, 16'd1);
    write_reg(REG_DATA_TIMEOUT, 16'd1);
    timeout_run(3);
    exchange(0, 2, 0);
    drain();
    write_reg(REG_ACK_TIMEOUT, 16'd3);
    write_reg(REG_DATA_TIMEOUT, 16'hFFFF);
    timeout_run(5);
    drain();

    send_idle_pct = 0; recv_stall_pct = 0;
    random_phase(5);
    drain();
    write_reg(REG_ACK_TIMEOUT, 16'hFFFF);
    write_reg(REG_DATA_TIMEOUT, 16'd2);
    send_idle_pct = 47; recv_stall_pct = 0;
    random_phase(5);
    drain();
    write_reg(REG_ACK_TIMEOUT, 16'd2);
    write_reg(REG_DATA_TIMEOUT, 16'd3000);
    send_idle_pct = 0; recv_stall_pct = 47;
    random_phase(5);
    drain();
    send_idle_pct = 18; recv_stall_pct = 18;
    random_phase(5);
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
